[rtl/binary_to_bcd_digits_core_assert.svh]
// Assertion macros used by the binary-to-BCD checker file.
`ifndef BINARY_TO_BCD_DIGITS_CORE_ASSERT_SVH
`define BINARY_TO_BCD_DIGITS_CORE_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define BBCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbcd assertion failed");

// Check a next-cycle implication on every clock edge outside reset.
`define BBCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbcd assertion failed");

`endif

[rtl/bbcd_pkg.sv]
// Shared types, constants and the double-dabble step for the BCD converter.
package bbcd_pkg;

  localparam int DataW         = 32;
  localparam int MaxDigits     = 10;
  localparam int BcdW          = 4 * MaxDigits;
  localparam int CountW        = 4;
  localparam int StepsPerStage = 8;
  localparam int NumStages     = DataW / StepsPerStage;

  // Working word of the shift-and-add-3 conversion
  typedef struct packed {
    logic [BcdW-1:0]  bcd;
    logic [DataW-1:0] bin;
  } bbcd_work_t;

  // One double-dabble iteration: correct each nibble, then shift left by one
  function automatic bbcd_work_t dabble_step(input bbcd_work_t w);
    bbcd_work_t r;
    logic [3:0] nib;
    r = w;
    for (int d = 0; d < MaxDigits; d++) begin
      nib = r.bcd[4*d +: 4];
      if (nib >= 4'd5) begin
        r.bcd[4*d +: 4] = nib + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd[BcdW-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

[rtl/bbcd_stage.sv]
// One pipeline stage running a fixed group of double-dabble iterations.
module bbcd_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  bbcd_pkg::bbcd_work_t s_work,
  output logic                m_valid,
  input  logic                m_ready,
  output bbcd_pkg::bbcd_work_t m_work
);
  import bbcd_pkg::*;

  logic       valid_r;
  bbcd_work_t work_r;
  bbcd_work_t work_nxt;

  // Run this stage's share of the iterations
  always_comb begin
    work_nxt = s_work;
    for (int s = 0; s < StepsPerStage; s++) begin
      work_nxt = dabble_step(work_nxt);
    end
  end

  // Load when empty or when the next stage takes the held beat
  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      work_r <= work_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_work  = work_r;

endmodule

[rtl/bbcd_fmt.sv]
// Output stage: digit-count check against the limit and result register.
module bbcd_fmt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bbcd_pkg::CountW-1:0]   digit_count,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [bbcd_pkg::BcdW-1:0]     s_bcd,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [bbcd_pkg::BcdW-1:0]     m_digits,
  output logic                          m_overflow
);
  import bbcd_pkg::*;

  logic              valid_r;
  logic [BcdW-1:0]   digits_r;
  logic              overflow_r;
  logic [CountW-1:0] need;
  logic [CountW-1:0] limit;
  logic              overflow_nxt;
  logic [BcdW-1:0]   digits_nxt;

  // Find the digits needed: highest nonzero nibble, zero still takes one
  always_comb begin
    need = CountW'(1);
    for (int d = 0; d < MaxDigits; d++) begin
      if (s_bcd[4*d +: 4] != 4'd0) begin
        need = CountW'(d + 1);
      end
    end
  end

  // Saturate the configured count and flag values that do not fit
  assign limit        = (digit_count > CountW'(MaxDigits)) ? CountW'(MaxDigits) : digit_count;
  assign overflow_nxt = need > limit;
  assign digits_nxt   = overflow_nxt ? '0 : s_bcd;

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      digits_r   <= digits_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  assign m_valid    = valid_r;
  assign m_digits   = digits_r;
  assign m_overflow = overflow_r;

endmodule

[rtl/binary_to_bcd_digits_core.sv]
// Top level of the 32-bit binary to BCD converter with digit-count check.
// Throughput: one beat per cycle while out_tready does not stall the output; four
// double-dabble stages of eight iterations each plus a check stage, every stage
// registered with its own valid bit.
// Reset (rst_n low, synchronous): all stages empty, digit_count back to 10.
module binary_to_bcd_digits_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bbcd_pkg::DataW-1:0]  in_tdata,   // [31:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bbcd_pkg::BcdW-1:0]   out_tdata,  // [39:0] digits_packed
  output logic                        out_tuser,  // [0] overflow_error
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbcd_pkg::CountW-1:0] cfg_data    // [3:0] digit_count
);
  import bbcd_pkg::*;

  logic [CountW-1:0] digit_count_r;

  logic       st_valid [NumStages+1];
  logic       st_ready [NumStages+1];
  bbcd_work_t st_work  [NumStages+1];

  // Take configuration beats at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= CountW'(MaxDigits);
    end else if (cfg_valid) begin
      digit_count_r <= cfg_data;
    end
  end

  // Feed the first stage with an empty BCD field
  assign st_valid[0]     = in_tvalid;
  assign in_tready       = st_ready[0];
  assign st_work[0].bcd  = '0;
  assign st_work[0].bin  = in_tdata;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    bbcd_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (st_valid[g]),
      .s_ready (st_ready[g]),
      .s_work  (st_work[g]),
      .m_valid (st_valid[g+1]),
      .m_ready (st_ready[g+1]),
      .m_work  (st_work[g+1])
    );
  end

  bbcd_fmt u_fmt (
    .clk         (clk),
    .rst_n       (rst_n),
    .digit_count (digit_count_r),
    .s_valid     (st_valid[NumStages]),
    .s_ready     (st_ready[NumStages]),
    .s_bcd       (st_work[NumStages].bcd),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .m_digits    (out_tdata),
    .m_overflow  (out_tuser)
  );

endmodule

[rtl/bbcd_checker.sv]
// Port-level checker for the BCD converter, bound to the top level.
`include "binary_to_bcd_digits_core_assert.svh"

module bbcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);
  logic digits_ok;

  // Every nibble of a result must be a decimal digit
  always_comb begin
    digits_ok = 1'b1;
    for (int d = 0; d < 10; d++) begin
      if (out_tdata[4*d +: 4] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

  `BBCD_ASSERT_IMPL(a_ovf_zero, out_tvalid && out_tuser, out_tdata == 40'd0)
  `BBCD_ASSERT_IMPL(a_decimal, out_tvalid, digits_ok)
  `BBCD_ASSERT_IMPL(a_no_bubble, out_tready, in_tready)
  `BBCD_ASSERT_NEXT(a_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind binary_to_bcd_digits_core bbcd_checker u_bbcd_checker (.*);

[tb/tb_binary_to_bcd_digits_core.sv]
// Self-checking testbench for the binary to BCD digit converter.
module tb_binary_to_bcd_digits_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bbcd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [BcdW-1:0] digits;
    logic            overflow;
  } bcd_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DataW-1:0]     in_tdata;   // [31:0] value
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [BcdW-1:0]      out_tdata;  // [39:0] digits_packed
  logic                 out_tuser;  // [0] overflow_error
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CountW-1:0]    cfg_data;   // [3:0] digit_count

  bcd_result_t          pending_bcd_q[$];
  logic [CountW-1:0]    digit_count_model;
  bit                   idle_on;
  int unsigned          stall_left = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          fail_count = 0;
  int unsigned          values_sent = 0;
  int unsigned          results_seen = 0;
  int unsigned          overflows_seen = 0;
  int unsigned          count_writes = 0;

  binary_to_bcd_digits_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Expected digits for one value under a given digit count
  function automatic bcd_result_t convert_value(input logic [DataW-1:0] v,
                                                input logic [CountW-1:0] count);
    bcd_result_t r;
    logic [DataW-1:0] rem;
    int unsigned limit;
    int unsigned places;
    limit = (count > MaxDigits) ? MaxDigits : count;
    places = 1;
    rem = v;
    while (rem >= 10) begin
      rem = rem / 10;
      places++;
    end
    r.digits = '0;
    r.overflow = 1'b0;
    if (places > limit) begin
      r.overflow = 1'b1;
    end else begin
      rem = v;
      for (int i = 0; i < MaxDigits; i++) begin
        r.digits[4*i +: 4] = 4'(rem % 10);
        rem = rem / 10;
      end
    end
    return r;
  endfunction

  // Random value, biased toward decimal-width boundaries and short numbers
  function automatic logic [DataW-1:0] pick_value();
    logic [63:0] p;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: pick_value = $urandom;
      1: pick_value = $urandom >> $urandom_range(0, 31);
      2: begin
        k = $urandom_range(0, 9);
        p = 64'd1;
        repeat (k) p = p * 10;
        pick_value = DataW'(p - 1 + $urandom_range(0, 2));
      end
      default: pick_value = $urandom_range(0, 99);
    endcase
  endfunction

  // Send one value beat, with an occasional idle burst ahead of it
  task automatic send_value(input logic [DataW-1:0] v);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_bcd_q.push_back(convert_value(v, digit_count_model));
    values_sent++;
  endtask

  // Hold off input until the pipeline has emptied
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_bcd_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write digit_count once the block is idle
  task automatic write_digit_count(input logic [CountW-1:0] count);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    digit_count_model = count;
    count_writes++;
  endtask

  // Field extremes, decade edges and every special case of the count
  task automatic test_directed();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd99);
    send_value(32'd100);
    send_value(32'd999999999);
    send_value(32'd1000000000);
    send_value(32'hFFFF_FFFF);
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);
    send_value(32'd12345678);
    // zero count rejects everything, zero included
    write_digit_count(4'd0);
    send_value(32'd0);
    send_value(32'd5);
    // counts above the maximum saturate
    write_digit_count(4'd15);
    send_value(32'hFFFF_FFFF);
    send_value(32'd0);
    write_digit_count(4'd1);
    send_value(32'd9);
    send_value(32'd10);
    write_digit_count(4'd3);
    send_value(32'd999);
    send_value(32'd1000);
  endtask

  // Every digit count, with a handful of values under each
  task automatic test_count_sweep();
    for (int c = 0; c < 16; c++) begin
      write_digit_count(CountW'(c));
      repeat (20) send_value(pick_value());
    end
  endtask

  // Random counts and values, quiet stretches and a full drain midway through each of four phases
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_digit_count(CountW'($urandom_range(0, 15)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (35) send_value(pick_value());
      wait_drained();
      repeat (35) send_value(pick_value());
    end
    idle_on = 1'b1;
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_streaming_tail();
    idle_on = 1'b0;
    write_digit_count(4'd10);
    repeat (50) send_value(pick_value());
    write_digit_count(CountW'($urandom_range(4, 9)));
    repeat (50) send_value(pick_value());
  endtask

  // Result-side stalls in random bursts, started only while idle_on is set
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_tready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    bcd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) overflows_seen++;
      if (pending_bcd_q.size() == 0) begin
        $error("result beat with no conversion pending: digits_packed=%h overflow_error=%b",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_bcd_q.pop_front();
        if (out_tdata !== want.digits) begin
          $error("digits_packed: expected %h, got %h", want.digits, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.overflow) begin
          $error("overflow_error: expected %b, got %b", want.overflow, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Abort if no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", StallLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    digit_count_model = 4'd10;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_count_sweep();
    test_random_traffic();
    test_streaming_tail();
    wait_drained();

    if (pending_bcd_q.size() != 0) begin
      $error("%0d results never arrived", pending_bcd_q.size());
      fail_count++;
    end
    $display("Converted %0d values (%0d results, %0d overflow) over %0d digit-count writes,",
             values_sent, results_seen, overflows_seen, count_writes);
    $display("with random stalls on both sides, repeated full drains and a back-to-back tail.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
